### sv/mtfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfq_pkg
// Shared types and constants of the move-to-front queue: command and result
// beats, action codes and controller states.
// ----------------------------------------------------------------------------
package mtfq_pkg;

	localparam int MTFQ_DEPTH       = 16;
	localparam int MTFQ_VALUE_WIDTH = 32;
	localparam int DATA_W           = 32;
	localparam int COUNT_OUT_W      = 5;

	typedef enum logic [1:0] {
		ACT_ENQUEUE = 2'd0,
		ACT_DEQUEUE = 2'd1,
		ACT_PROMOTE = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEQ,
		ST_SCAN,
		ST_SHIFT,
		ST_PLACE
	} state_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0]      value_out;
		logic                   ok;
		logic [COUNT_OUT_W-1:0] entry_count;
	} result_t;

endpackage

### sv/mtfq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfq_mem
// Entry store of the queue: one write port, one read port, registered read
// data.
// ----------------------------------------------------------------------------
module mtfq_mem #(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(DEPTH)-1:0]       wr_addr,
	input  logic [VALUE_WIDTH-1:0]         wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(DEPTH)-1:0]       rd_addr,
	output logic [VALUE_WIDTH-1:0]         rd_data
);

	logic [VALUE_WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/move_to_front_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_queue_top
// Bounded queue kept as a ring in one entry memory, with enqueue, dequeue and
// promote (move the first matching entry to the head).
//
//   channel   signals               beat taken when
//   command   start, busy, cmd      start high and busy low at a rising edge
//   result    done, result          done high (one cycle, no back-pressure)
//
// enqueue, unused codes, dequeue or promote on an empty queue: result on
// the next cycle
// dequeue: one memory read
// promote: hit at the head ends in the scan, hit at logical position p > 0
// adds a shift and a place step, a miss scans every entry; the single memory
// read port scans from the head, then shifts the front entries up by one
// reset clears occupancy and pointers at once; no clearing pass
// ----------------------------------------------------------------------------
module move_to_front_queue_top #(
	parameter int DEPTH       = mtfq_pkg::MTFQ_DEPTH,
	parameter int VALUE_WIDTH = mtfq_pkg::MTFQ_VALUE_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mtfq_pkg::cmd_t    cmd,
	output logic              done,
	output mtfq_pkg::result_t result
);

	import mtfq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? LAST_PTR : p - PTR_W'(1);
	endfunction

	state_t state_q, state_d;
	logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic done_q, done_d;

	logic [VALUE_WIDTH-1:0] key_q, key_d, hit_q, hit_d;
	logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d, wp_q, wp_d, left_q, left_d;
	logic [PTR_W-1:0] cmp_ptr_s1, cmp_ptr_d;
	logic [CNT_W-1:0] cmp_pos_s1, cmp_pos_d, cmp_next;
	logic [VALUE_WIDTH-1:0] res_val_q, res_val_d;
	logic res_ok_q, res_ok_d;
	logic [CNT_W-1:0] res_cnt_q, res_cnt_d;

	logic wr_en, rd_en;
	logic [PTR_W-1:0] wr_addr, rd_addr;
	logic [VALUE_WIDTH-1:0] wr_data, rd_data, v_in;

	logic acc, is_full, is_empty, hit_now, head_hit, scan_last, shift_last;

	assign busy       = (state_q != ST_IDLE);
	assign acc        = start && !busy;
	assign v_in       = VALUE_WIDTH'(cmd.value);
	assign is_full    = (count_q == CNT_W'(DEPTH));
	assign is_empty   = (count_q == '0);
	assign hit_now    = (rd_data == key_q);
	assign head_hit   = (cmp_pos_s1 == '0);
	assign cmp_next   = cmp_pos_s1 + CNT_W'(1);
	assign scan_last  = (cmp_next == count_q);
	assign shift_last = (left_q == PTR_W'(1));

	mtfq_mem #(
		.DEPTH(DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && !is_empty) begin
					if (cmd.action == ACT_DEQUEUE) begin
						state_d = ST_DEQ;
					end else if (cmd.action == ACT_PROMOTE) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_DEQ: state_d = ST_IDLE;
			ST_SCAN: begin
				if (hit_now) begin
					state_d = head_hit ? ST_IDLE : ST_SHIFT;
				end else if (scan_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				if (shift_last) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory control and register updates
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = tail_q;
		wr_data   = v_in;
		rd_en     = 1'b0;
		rd_addr   = rd_ptr_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		key_d     = key_q;
		hit_d     = hit_q;
		rd_ptr_d  = rd_ptr_q;
		wp_d      = wp_q;
		left_d    = left_q;
		cmp_ptr_d = cmp_ptr_s1;
		cmp_pos_d = cmp_pos_s1;
		done_d    = 1'b0;
		res_val_d = '0;
		res_ok_d  = 1'b0;
		res_cnt_d = count_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (cmd.action)
						ACT_ENQUEUE: begin
							done_d = 1'b1;
							if (!is_full) begin
								wr_en     = 1'b1;
								tail_d    = ptr_inc(tail_q);
								count_d   = count_q + CNT_W'(1);
								res_ok_d  = 1'b1;
								res_cnt_d = count_q + CNT_W'(1);
							end
						end
						ACT_DEQUEUE: begin
							if (is_empty) begin
								done_d = 1'b1;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q;
								head_d  = ptr_inc(head_q);
								count_d = count_q - CNT_W'(1);
							end
						end
						ACT_PROMOTE: begin
							if (is_empty) begin
								done_d = 1'b1;
							end else begin
								rd_en     = 1'b1;
								rd_addr   = head_q;
								rd_ptr_d  = ptr_inc(head_q);
								cmp_ptr_d = head_q;
								cmp_pos_d = '0;
								key_d     = v_in;
							end
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			ST_DEQ: begin
				done_d    = 1'b1;
				res_ok_d  = 1'b1;
				res_val_d = rd_data;
			end
			ST_SCAN: begin
				if (hit_now) begin
					if (head_hit) begin
						done_d   = 1'b1;
						res_ok_d = 1'b1;
					end else begin
						hit_d    = rd_data;
						rd_en    = 1'b1;
						rd_addr  = ptr_dec(cmp_ptr_s1);
						rd_ptr_d = ptr_dec(ptr_dec(cmp_ptr_s1));
						wp_d     = cmp_ptr_s1;
						left_d   = PTR_W'(cmp_pos_s1);
					end
				end else if (scan_last) begin
					done_d = 1'b1;
				end else begin
					rd_en     = 1'b1;
					rd_addr   = rd_ptr_q;
					rd_ptr_d  = ptr_inc(rd_ptr_q);
					cmp_ptr_d = rd_ptr_q;
					cmp_pos_d = cmp_next;
				end
			end
			ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = wp_q;
				wr_data = rd_data;
				wp_d    = ptr_dec(wp_q);
				left_d  = left_q - PTR_W'(1);
				if (!shift_last) begin
					rd_en    = 1'b1;
					rd_addr  = rd_ptr_q;
					rd_ptr_d = ptr_dec(rd_ptr_q);
				end
			end
			ST_PLACE: begin
				wr_en    = 1'b1;
				wr_addr  = head_q;
				wr_data  = hit_q;
				done_d   = 1'b1;
				res_ok_d = 1'b1;
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q      <= key_d;
		hit_q      <= hit_d;
		rd_ptr_q   <= rd_ptr_d;
		wp_q       <= wp_d;
		left_q     <= left_d;
		cmp_ptr_s1 <= cmp_ptr_d;
		cmp_pos_s1 <= cmp_pos_d;
		if (done_d) begin
			res_val_q <= res_val_d;
			res_ok_q  <= res_ok_d;
			res_cnt_q <= res_cnt_d;
		end
	end

	assign done               = done_q;
	assign result.value_out   = DATA_W'(res_val_q);
	assign result.ok          = res_ok_q;
	assign result.entry_count = COUNT_OUT_W'(res_cnt_q);

endmodule

### sv/mtfq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfq_checker
// Port-level checks of the move-to-front queue, bound to the top level.
// ----------------------------------------------------------------------------
module mtfq_checker #(
	parameter int DEPTH = mtfq_pkg::MTFQ_DEPTH
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input mtfq_pkg::cmd_t    cmd,
	input logic              done,
	input mtfq_pkg::result_t result
);

	import mtfq_pkg::*;

	// a result beat never overlaps a command in flight
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_enq_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.action == ACT_ENQUEUE) |=> done)
		else $error("enqueue result missing");

	a_deq_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.action == ACT_DEQUEUE) |=> (done || busy))
		else $error("dequeue neither finished nor in progress");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.ok) |-> (result.value_out == '0))
		else $error("value on failed action");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((DEPTH > 31) || (int'(result.entry_count) <= DEPTH)))
		else $error("entry count above depth");

endmodule

bind move_to_front_queue_top mtfq_checker #(
	.DEPTH(DEPTH)
) u_mtfq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.cmd(cmd),
	.done(done),
	.result(result)
);
